/* design/udr_pkg.sv */
// Shared types, constants and register codes of the dual echo ranger.
package udr_pkg;

  localparam int COUNT_WIDTH_DEF = 20;

  localparam int TRIG_W    = 10;
  localparam int TIMEOUT_W = 20;
  localparam int GAP_W     = 18;
  localparam int SCALE_W   = 12;
  localparam int DIST_W    = 8;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_GAP     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CM_SCALE      = 8'd3;

  localparam logic [TRIG_W-1:0]    TRIGGER_TICKS_RST = 10'd10;
  localparam logic [TIMEOUT_W-1:0] ECHO_TIMEOUT_RST  = 20'd1000000;
  localparam logic [GAP_W-1:0]     ROUND_GAP_RST     = 18'd100000;
  localparam logic [SCALE_W-1:0]   CM_SCALE_RST      = 12'd1124;

  typedef enum logic [3:0] {
    PH_TRIG_A = 4'd0,
    PH_WAIT_A = 4'd1,
    PH_MEAS_A = 4'd2,
    PH_TRIG_B = 4'd3,
    PH_WAIT_B = 4'd4,
    PH_MEAS_B = 4'd5,
    PH_GAP    = 4'd6
  } phase_t;

  typedef struct packed {
    logic [TRIG_W-1:0]    trigger_ticks;
    logic [TIMEOUT_W-1:0] echo_timeout_ticks;
    logic [GAP_W-1:0]     round_gap_ticks;
    logic [SCALE_W-1:0]   cm_scale_q16;
  } udr_cfg_t;

  typedef struct packed {
    logic              trig_a;
    logic              trig_b;
    logic              round_done;
    logic [DIST_W-1:0] distance_a;
    logic [DIST_W-1:0] distance_b;
    logic [DIST_W-1:0] mean_distance;
  } udr_result_t;

endpackage

/* design/udr_if.sv */
// Channel interfaces: tick samples, result items and configuration writes.
interface udr_in_if;
  logic valid;
  logic ready;
  logic echo_a;
  logic echo_b;
  modport source (output valid, echo_a, echo_b, input ready);
  modport sink (input valid, echo_a, echo_b, output ready);
endinterface

interface udr_out_if;
  logic       valid;
  logic       ready;
  logic       trig_a;
  logic       trig_b;
  logic       round_done;
  logic [7:0] distance_a;
  logic [7:0] distance_b;
  logic [7:0] mean_distance;
  modport source (output valid, trig_a, trig_b, round_done, distance_a, distance_b,
                  mean_distance, input ready);
  modport sink (input valid, trig_a, trig_b, round_done, distance_a, distance_b,
                mean_distance, output ready);
endinterface

interface udr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/udr_cfg_regs.sv */
// Configuration register file of the dual echo ranger.
module udr_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  udr_cfg_if.sink           cfg,
  output udr_pkg::udr_cfg_t regs
);
  import udr_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.trigger_ticks      <= TRIGGER_TICKS_RST;
      regs.echo_timeout_ticks <= ECHO_TIMEOUT_RST;
      regs.round_gap_ticks    <= ROUND_GAP_RST;
      regs.cm_scale_q16       <= CM_SCALE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TRIGGER_TICKS: regs.trigger_ticks      <= cfg.data[TRIG_W-1:0];
        REG_ECHO_TIMEOUT:  regs.echo_timeout_ticks <= cfg.data[TIMEOUT_W-1:0];
        REG_ROUND_GAP:     regs.round_gap_ticks    <= cfg.data[GAP_W-1:0];
        REG_CM_SCALE:      regs.cm_scale_q16       <= cfg.data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/udr_engine.sv */
// Ranging sequencer: phase register, tick counters, distance conversion.
module udr_engine #(
  parameter int COUNT_WIDTH = udr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 echo_a,
  input  logic                 echo_b,
  input  udr_pkg::udr_cfg_t    cfg,
  output udr_pkg::udr_result_t res
);
  import udr_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int TW = (CW > TIMEOUT_W) ? CW : TIMEOUT_W;
  localparam int PW = CW + SCALE_W;

  phase_t            phase, phase_next, ph_eff;
  logic [CW-1:0]     wait_count, wait_count_next;
  logic [CW-1:0]     pulse_width, pulse_width_next;
  logic [DIST_W-1:0] dist_a_reg, dist_a_reg_next;
  logic [DIST_W-1:0] dist_b_reg, dist_b_reg_next;
  logic [DIST_W-1:0] average_reg, average_reg_next;

  logic [CW-1:0]     wc_eff, wc_inc, eff_to;
  logic [TW-1:0]     to_ext, cmax_ext;
  logic [TRIG_W-1:0] trig_len;
  logic              trig_end, gap_end, echo, done;
  logic [PW-1:0]     product;
  logic [DIST_W-1:0] cm;
  logic [DIST_W:0]   sum;

  always_comb begin
    ph_eff   = (phase > PH_GAP) ? PH_TRIG_A : phase;
    wc_eff   = (phase > PH_GAP) ? '0 : wait_count;
    wc_inc   = wc_eff + CW'(1);
    trig_len = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;
    trig_end = wc_inc >= CW'(trig_len);
    gap_end  = TW'(wc_inc) >= TW'(cfg.round_gap_ticks);
    // Timeout saturates at the counter maximum.
    to_ext   = TW'(cfg.echo_timeout_ticks);
    cmax_ext = TW'({CW{1'b1}});
    eff_to   = CW'((to_ext < cmax_ext) ? to_ext : cmax_ext);
    // Width to centimetres in Q16, clamped to eight bits.
    product  = PW'(pulse_width) * PW'(cfg.cm_scale_q16);
    cm       = (product[PW-1:24] != '0) ? 8'hFF : product[23:16];
    echo     = (ph_eff == PH_WAIT_A || ph_eff == PH_MEAS_A) ? echo_a : echo_b;
  end

  always_comb begin
    phase_next       = ph_eff;
    wait_count_next  = wc_eff;
    pulse_width_next = pulse_width;
    dist_a_reg_next  = dist_a_reg;
    dist_b_reg_next  = dist_b_reg;
    average_reg_next = average_reg;
    done             = 1'b0;
    res.trig_a       = 1'b0;
    res.trig_b       = 1'b0;
    unique case (ph_eff) inside
      PH_TRIG_A, PH_TRIG_B: begin
        if (ph_eff == PH_TRIG_A) begin
          res.trig_a = 1'b1;
          if (wc_eff == '0) begin
            dist_a_reg_next  = '0;
            dist_b_reg_next  = '0;
            average_reg_next = '0;
          end
        end else begin
          res.trig_b = 1'b1;
        end
        if (trig_end) begin
          wait_count_next = '0;
          phase_next      = (ph_eff == PH_TRIG_A) ? PH_WAIT_A : PH_WAIT_B;
        end else begin
          wait_count_next = wc_inc;
        end
      end
      PH_WAIT_A, PH_WAIT_B: begin
        if (echo) begin
          pulse_width_next = CW'(1);
          wait_count_next  = '0;
          phase_next       = (ph_eff == PH_WAIT_A) ? PH_MEAS_A : PH_MEAS_B;
        end else if (wc_eff >= eff_to) begin
          wait_count_next = '0;
          if (ph_eff == PH_WAIT_A) phase_next = PH_TRIG_B;
          else done = 1'b1;
        end else begin
          wait_count_next = wc_inc;
        end
      end
      PH_MEAS_A, PH_MEAS_B: begin
        if (!echo || pulse_width >= eff_to) begin
          wait_count_next = '0;
          if (!echo) begin
            if (ph_eff == PH_MEAS_A) dist_a_reg_next = cm;
            else dist_b_reg_next = cm;
          end
          if (ph_eff == PH_MEAS_A) phase_next = PH_TRIG_B;
          else done = 1'b1;
        end else begin
          pulse_width_next = pulse_width + CW'(1);
        end
      end
      PH_GAP: begin
        if (gap_end) begin
          wait_count_next = '0;
          phase_next      = PH_TRIG_A;
        end else begin
          wait_count_next = wc_inc;
        end
      end
      default: begin
      end
    endcase

    sum = {1'b0, dist_a_reg_next} + {1'b0, dist_b_reg_next};
    if (done) begin
      average_reg_next = sum[DIST_W:1];
      wait_count_next  = '0;
      phase_next       = (cfg.round_gap_ticks == '0) ? PH_TRIG_A : PH_GAP;
    end

    res.round_done    = done;
    res.distance_a    = dist_a_reg_next;
    res.distance_b    = dist_b_reg_next;
    res.mean_distance = average_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TRIG_A;
      wait_count  <= '0;
      pulse_width <= '0;
      dist_a_reg  <= '0;
      dist_b_reg  <= '0;
      average_reg <= '0;
    end else if (step) begin
      phase       <= phase_next;
      wait_count  <= wait_count_next;
      pulse_width <= pulse_width_next;
      dist_a_reg  <= dist_a_reg_next;
      dist_b_reg  <= dist_b_reg_next;
      average_reg <= average_reg_next;
    end
  end

endmodule

/* design/dual_ultrasonic_echo_ranger_core.sv */
// Top level of the dual ultrasonic echo ranger.
//
// Each item on the sample channel is one timer tick (nominally one
// microsecond) carrying the sampled echo levels of sensors A and B. For every
// item exactly one result item leaves on the result channel: the trigger pin
// drives for that tick, a round_done flag, both distances and their floor mean.
// A round triggers sensor A, times its echo, then does the same for sensor B,
// reports the average and idles for the programmed gap.
// The cfg channel writes the four registers by index (trigger length, echo
// timeout, round gap, Q16 scale); it is always ready, and writes to unknown
// indexes are dropped. Registers should only be written while the block idles.
// The tick lands in an input register, and the sequencer then writes the result
// register. Throughput is one item every cycle while the receiver does not stall;
// the sequencer logic between those registers holds a single COUNT_WIDTH by 12
// bit multiplier (20x12 at the default counter width).
// The result register is a one-deep output stage, so a new tick is taken
// while a finished result waits as long as the input register is empty or
// moves on in the same cycle. When the receiver stalls, the pipeline holds
// and sample.ready falls once both stages are full; nothing is lost.
// Reset (synchronous, active high) empties both stages, restores the register
// defaults and starts a fresh round at trigger A with all distances zero.
module dual_ultrasonic_echo_ranger_core #(
  parameter int COUNT_WIDTH = udr_pkg::COUNT_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  udr_in_if.sink     sample,
  udr_out_if.source  result,
  udr_cfg_if.sink    cfg
);
  import udr_pkg::*;

  udr_cfg_t    cfg_regs;
  udr_result_t res_next;
  udr_result_t res_reg;

  logic s1_valid;
  logic s1_echo_a;
  logic s1_echo_b;
  logic out_valid;
  logic out_free;
  logic step;

  // The output stage can take a new result when empty or when drained now.
  assign out_free     = !out_valid || result.ready;
  assign step         = s1_valid && out_free;
  assign sample.ready = !s1_valid || step;

  udr_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  // The sequencer state advances only when a tick moves into the output stage.
  udr_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .echo_a (s1_echo_a),
    .echo_b (s1_echo_b),
    .cfg    (cfg_regs),
    .res    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sample.ready) s1_valid <= sample.valid;
      if (out_free) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_echo_a <= sample.echo_a;
      s1_echo_b <= sample.echo_b;
    end
    if (step) res_reg <= res_next;
  end

  assign result.valid         = out_valid;
  assign result.trig_a        = res_reg.trig_a;
  assign result.trig_b        = res_reg.trig_b;
  assign result.round_done    = res_reg.round_done;
  assign result.distance_a    = res_reg.distance_a;
  assign result.distance_b    = res_reg.distance_b;
  assign result.mean_distance = res_reg.mean_distance;

endmodule

/* design/udr_checker.sv */
// Port-level checks of the dual echo ranger and their bind to the top level.
module udr_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       trig_a,
  input logic       trig_b,
  input logic       round_done,
  input logic [7:0] distance_a,
  input logic [7:0] distance_b,
  input logic [7:0] mean_distance
);

  // A stalled result stays valid and keeps its round_done flag and distances.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(mean_distance)
      && $stable(round_done) && $stable(distance_a) && $stable(distance_b))
    else $error("stalled result item changed");

  // Only one sensor is ever triggered at a time.
  a_one_trig: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(trig_a && trig_b))
    else $error("both triggers driven");

  // A report tick is never a trigger tick.
  a_done_no_trig: assert property (@(posedge clk) disable iff (rst)
    res_valid && round_done |-> !trig_a && !trig_b)
    else $error("round_done during a trigger");

  // The reported average is the floor mean of the two distances.
  a_average: assert property (@(posedge clk) disable iff (rst)
    res_valid && round_done
      |-> mean_distance == 8'(({1'b0, distance_a} + {1'b0, distance_b}) >> 1))
    else $error("average does not match distances");

endmodule

bind dual_ultrasonic_echo_ranger_core udr_checker u_udr_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .trig_a        (result.trig_a),
  .trig_b        (result.trig_b),
  .round_done    (result.round_done),
  .distance_a    (result.distance_a),
  .distance_b    (result.distance_b),
  .mean_distance (result.mean_distance)
);
